// ===== rtl/core/kele_pkg.sv =====
// package for the keyed entry list engine: sizes, codes and beat types
// shared by kele_split and keyed_entry_list_engine_unit
// no dependencies
package kele_pkg;

	// list store size
	localparam int DEPTH  = 64;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int CNT_W  = $clog2(DEPTH + 1);

	// field widths
	localparam int ACTION_W = 3;
	localparam int VALUE_W  = 27;
	localparam int MODEL_W  = 17;
	localparam int SPEED_W  = 10;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 7;

	// decimal split: value / 1000 through a reciprocal multiply
	localparam int SCALE    = 1000;
	localparam int SCALE_W  = 10;
	localparam int RECIP_SH = 37;
	localparam int RECIP_W  = 28;
	localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(
		((64'd1 << RECIP_SH) + 64'(SCALE) - 64'd1) / 64'(SCALE));
	localparam int PROD_W = VALUE_W + RECIP_W;
	localparam int QUOT_W = PROD_W - RECIP_SH;

	// action codes
	localparam logic [ACTION_W-1:0] ACT_APPEND   = 3'd0;
	localparam logic [ACTION_W-1:0] ACT_PREPEND  = 3'd1;
	localparam logic [ACTION_W-1:0] ACT_DELETE   = 3'd2;
	localparam logic [ACTION_W-1:0] ACT_ENDS     = 3'd3;
	localparam logic [ACTION_W-1:0] ACT_EXTREMES = 3'd4;

	// status codes
	localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
	localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd3;

	// request beat
	typedef struct packed {
		logic [ACTION_W-1:0] action;
		logic [VALUE_W-1:0]  entry_value;
		logic [MODEL_W-1:0]  model;
		logic [SPEED_W-1:0]  speed;
	} kele_req_t;

	// response beat
	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [COUNT_W-1:0]  count;
		logic [VALUE_W-1:0]  first_entry;
		logic [VALUE_W-1:0]  second_last_entry;
		logic [MODEL_W-1:0]  fastest_model;
		logic [SPEED_W-1:0]  fastest_speed;
		logic [MODEL_W-1:0]  slowest_model;
		logic [SPEED_W-1:0]  slowest_speed;
	} kele_rsp_t;

	// split unit output: quotient and remainder by 1000
	typedef struct packed {
		logic               valid;
		logic [QUOT_W-1:0]  quot;
		logic [SPEED_W-1:0] rem;
	} kele_split_t;

endpackage

// ===== rtl/core/kele_split.sv =====
// two-stage split of a packed entry into model (value / 1000) and speed (value % 1000)
// depends on kele_pkg
module kele_split (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    valid,
	input  logic [kele_pkg::VALUE_W-1:0] value,
	output kele_pkg::kele_split_t   res
);
	import kele_pkg::*;

	logic               valid_s1;
	logic [PROD_W-1:0]  prod_s1;
	logic [VALUE_W-1:0] value_s1;
	logic               valid_s2;
	logic [QUOT_W-1:0]  quot_s2;
	logic [SPEED_W-1:0] rem_s2;

	logic [QUOT_W-1:0]         quot;
	logic [QUOT_W+SCALE_W-1:0] back;
	logic [VALUE_W-1:0]        diff;

	// quotient from the product, remainder by subtracting quot * 1000
	assign quot = prod_s1[PROD_W-1:RECIP_SH];
	assign back = quot * SCALE_W'(SCALE);
	assign diff = value_s1 - back[VALUE_W-1:0];

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= valid;
			valid_s2 <= valid_s1;
		end
	end

	// data stages
	always_ff @(posedge clk) begin
		prod_s1  <= PROD_W'(value) * PROD_W'(RECIP);
		value_s1 <= value;
		quot_s2  <= quot;
		rem_s2   <= diff[SPEED_W-1:0];
	end

	assign res.valid = valid_s2;
	assign res.quot  = quot_s2;
	assign res.rem   = rem_s2;

endmodule

// ===== rtl/core/keyed_entry_list_engine_unit.sv =====
// top level of the keyed entry list engine: entry store, sequencer, response register
// depends on kele_pkg and kele_split
//
// Usage: a request beat on req (req_valid/req_ready) carries one action: append,
// prepend, delete by model, query ends or query extremes. Each request yields
// exactly one response beat on rsp (rsp_valid/rsp_ready) with status and count.
// The block works on one request at a time; req_ready is high only while the
// sequencer is idle. Prepend moves each held entry up one store place, one per
// cycle; query extremes and delete scan every entry, one per cycle, through the
// split unit, and a delete hit then moves each entry after the hit down one place.
// The store has one write and one read port with registered read data; scans
// go through that port and the shared divide-by-1000 unit, and moves go through
// the store ports alone.
// The response sits in an output register: a new request is taken while the
// last response still waits, and the sequencer holds its next response until
// the receiver takes the old one. Reset empties the list (count zero) and
// drops any pending response; the store itself is not cleared.
module keyed_entry_list_engine_unit (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_ready,
	input  kele_pkg::kele_req_t  req,
	output logic                 rsp_valid,
	input  logic                 rsp_ready,
	output kele_pkg::kele_rsp_t  rsp
);
	import kele_pkg::*;

	// sequencer states
	localparam logic [2:0] S_IDLE     = 3'd0;
	localparam logic [2:0] S_SCAN     = 3'd1;
	localparam logic [2:0] S_SHIFT_UP = 3'd2;
	localparam logic [2:0] S_SHIFT_DN = 3'd3;
	localparam logic [2:0] S_ENDS_A   = 3'd4;
	localparam logic [2:0] S_ENDS_B   = 3'd5;
	localparam logic [2:0] S_ENDS_C   = 3'd6;
	localparam logic [2:0] S_RESP     = 3'd7;

	logic [2:0] state_q;

	// entry store
	logic [VALUE_W-1:0] mem [DEPTH];
	logic [VALUE_W-1:0] rd_q;
	logic [ADDR_W-1:0]  ra;
	logic               we;
	logic [ADDR_W-1:0]  wa;
	logic [VALUE_W-1:0] wd;

	// list and sequencer state
	logic [CNT_W-1:0]    cnt_q;
	logic [CNT_W-1:0]    iss_q;
	logic [CNT_W-1:0]    ret_q;
	logic [CNT_W-1:0]    sp_q;
	logic [ADDR_W-1:0]   hit_q;
	logic                found_q;
	logic [ACTION_W-1:0] act_q;
	logic [MODEL_W-1:0]  key_q;
	logic [VALUE_W-1:0]  pk_q;
	logic                rv_s1;
	logic                wv_s1;
	logic [ADDR_W-1:0]   wa_s1;

	// running extremes
	logic [QUOT_W-1:0]  fq_q;
	logic [SPEED_W-1:0] fr_q;
	logic [QUOT_W-1:0]  sq_q;
	logic [SPEED_W-1:0] sr_q;

	// result in progress and output register
	kele_rsp_t res_q;
	kele_rsp_t res_init;
	kele_rsp_t rsp_next;
	kele_rsp_t rsp_q;
	logic      rsp_valid_q;

	kele_split_t sp_res;

	logic accept;
	logic full;
	logic issue;
	logic [VALUE_W+SCALE_W-1:0] pk_wide;

	assign req_ready = (state_q == S_IDLE);
	assign accept    = req_valid && req_ready;
	assign full      = (cnt_q == CNT_W'(DEPTH));
	assign issue     = (state_q == S_SCAN) && (iss_q < cnt_q);
	assign pk_wide   = (VALUE_W+SCALE_W)'(req.model) * SCALE_W'(SCALE)
		+ (VALUE_W+SCALE_W)'(req.speed);

	// shared divide-by-1000 unit
	kele_split u_split (
		.clk   (clk),
		.arst_n(arst_n),
		.valid (rv_s1),
		.value (rd_q),
		.res   (sp_res)
	);

	// read address per state
	always_comb begin
		unique case (state_q)
			S_SCAN:     ra = iss_q[ADDR_W-1:0];
			S_SHIFT_UP: ra = ADDR_W'(sp_q - CNT_W'(1));
			S_SHIFT_DN: ra = ADDR_W'(sp_q);
			S_ENDS_B:   ra = ADDR_W'(cnt_q - CNT_W'(2));
			default:    ra = '0;
		endcase
	end

	// write port: moved entry, appended entry, or new head
	always_comb begin
		we = 1'b0;
		wa = '0;
		wd = rd_q;
		if (wv_s1) begin
			we = 1'b1;
			wa = wa_s1;
		end else if (accept && req.action == ACT_APPEND && !full) begin
			we = 1'b1;
			wa = cnt_q[ADDR_W-1:0];
			wd = req.entry_value;
		end else if (state_q == S_SHIFT_UP && sp_q == '0) begin
			we = 1'b1;
			wa = '0;
			wd = pk_q;
		end
	end

	// store array
	always_ff @(posedge clk) begin
		if (we)
			mem[wa] <= wd;
		rd_q <= mem[ra];
	end

	// cleared result with the status known at request time
	always_comb begin
		res_init = '0;
		case (req.action) inside
			ACT_APPEND, ACT_PREPEND:
				res_init.status = full ? ST_FULL : ST_OK;
			ACT_DELETE, ACT_ENDS, ACT_EXTREMES:
				res_init.status = (cnt_q == '0) ? ST_EMPTY : ST_OK;
			default:
				res_init.status = ST_OK;
		endcase
	end

	// result with the count after the item
	always_comb begin
		rsp_next       = res_q;
		rsp_next.count = COUNT_W'(cnt_q);
	end

	// sequencer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			iss_q       <= '0;
			ret_q       <= '0;
			sp_q        <= '0;
			found_q     <= 1'b0;
			rv_s1       <= 1'b0;
			wv_s1       <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			rv_s1 <= issue;
			wv_s1 <= (state_q == S_SHIFT_UP && sp_q != '0)
				|| (state_q == S_SHIFT_DN && sp_q < cnt_q);
			if (state_q == S_RESP && (!rsp_valid_q || rsp_ready))
				rsp_valid_q <= 1'b1;
			else if (rsp_ready)
				rsp_valid_q <= 1'b0;

			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						iss_q   <= '0;
						ret_q   <= '0;
						found_q <= 1'b0;
						sp_q    <= cnt_q;
						case (req.action) inside
							ACT_APPEND, ACT_PREPEND: begin
								if (full)
									state_q <= S_RESP;
								else if (req.action == ACT_APPEND) begin
									cnt_q   <= cnt_q + CNT_W'(1);
									state_q <= S_RESP;
								end else
									state_q <= S_SHIFT_UP;
							end
							ACT_DELETE, ACT_EXTREMES:
								state_q <= (cnt_q == '0) ? S_RESP : S_SCAN;
							ACT_ENDS:
								state_q <= (cnt_q == '0) ? S_RESP : S_ENDS_A;
							default:
								state_q <= S_RESP;
						endcase
					end
				end
				S_SCAN: begin
					if (issue)
						iss_q <= iss_q + CNT_W'(1);
					if (sp_res.valid) begin
						ret_q <= ret_q + CNT_W'(1);
						if (act_q == ACT_DELETE && !found_q
							&& sp_res.quot == QUOT_W'(key_q))
							found_q <= 1'b1;
					end
					if (ret_q == cnt_q) begin
						if (act_q == ACT_DELETE && found_q) begin
							sp_q    <= CNT_W'(hit_q) + CNT_W'(1);
							state_q <= S_SHIFT_DN;
						end else
							state_q <= S_RESP;
					end
				end
				S_SHIFT_UP: begin
					if (sp_q != '0)
						sp_q <= sp_q - CNT_W'(1);
					else if (!wv_s1) begin
						cnt_q   <= cnt_q + CNT_W'(1);
						state_q <= S_RESP;
					end
				end
				S_SHIFT_DN: begin
					if (sp_q < cnt_q)
						sp_q <= sp_q + CNT_W'(1);
					else if (!wv_s1) begin
						cnt_q   <= cnt_q - CNT_W'(1);
						state_q <= S_RESP;
					end
				end
				S_ENDS_A: state_q <= S_ENDS_B;
				S_ENDS_B: state_q <= S_ENDS_C;
				S_ENDS_C: state_q <= S_RESP;
				S_RESP: begin
					if (!rsp_valid_q || rsp_ready)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// request fields, scan tracking, result build-up
	always_ff @(posedge clk) begin
		wa_s1 <= (state_q == S_SHIFT_UP) ? ADDR_W'(sp_q)
			: ADDR_W'(sp_q - CNT_W'(1));

		if (accept) begin
			act_q <= req.action;
			key_q <= req.model;
			pk_q  <= pk_wide[VALUE_W-1:0];
			res_q <= res_init;
		end

		// first match and running extremes from the split unit
		if (state_q == S_SCAN && sp_res.valid) begin
			if (act_q == ACT_DELETE && !found_q && sp_res.quot == QUOT_W'(key_q))
				hit_q <= ret_q[ADDR_W-1:0];
			if (ret_q == '0 || sp_res.rem > fr_q) begin
				fq_q <= sp_res.quot;
				fr_q <= sp_res.rem;
			end
			if (ret_q == '0 || sp_res.rem < sr_q) begin
				sq_q <= sp_res.quot;
				sr_q <= sp_res.rem;
			end
		end

		// scan outcome
		if (state_q == S_SCAN && ret_q == cnt_q) begin
			if (act_q == ACT_DELETE) begin
				if (!found_q)
					res_q.status <= ST_NOT_FOUND;
			end else begin
				res_q.fastest_model <= fq_q[MODEL_W-1:0];
				res_q.fastest_speed <= fr_q;
				res_q.slowest_model <= sq_q[MODEL_W-1:0];
				res_q.slowest_speed <= sr_q;
			end
		end

		// head and second-to-last entry
		if (state_q == S_ENDS_B)
			res_q.first_entry <= rd_q;
		if (state_q == S_ENDS_C)
			res_q.second_last_entry <= (cnt_q >= CNT_W'(2)) ? rd_q : '0;

		// response register
		if (state_q == S_RESP && (!rsp_valid_q || rsp_ready))
			rsp_q <= rsp_next;
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// ===== tb/sv/tb.sv =====
// self-checking testbench for keyed_entry_list_engine_unit: a table of directed requests,
// then a random fill-and-drain mix, each checked against its typed row or a predictor
// depends on kele_pkg and the keyed_entry_list_engine_unit rtl
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import kele_pkg::*;

	// spare action codes with no effect on the list
	localparam logic [ACTION_W-1:0] ACT_SPARE_LO  = 3'd5;
	localparam logic [ACTION_W-1:0] ACT_SPARE_MID = 3'd6;
	localparam logic [ACTION_W-1:0] ACT_SPARE_HI  = 3'd7;

	localparam int unsigned DECIMAL     = 1000;
	localparam int          RANDOM_REQS = 1250;
	localparam int          CYCLE_LIMIT = 1000000;

	typedef struct {
		kele_req_t req;
		bit        typed;
		kele_rsp_t want;
	} stim_row_t;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      req_valid = 1'b0;
	logic      req_ready;
	kele_req_t req = '0;
	logic      rsp_valid;
	logic      rsp_ready = 1'b0;
	kele_rsp_t rsp;

	// predictor state and bookkeeping
	logic [VALUE_W-1:0] held_entries[$];
	kele_rsp_t          awaited_rsp[$];
	stim_row_t          directed_plan[$];
	int                 mismatch_count = 0;
	int                 outcome_tally[4] = '{0, 0, 0, 0};
	int                 peak_fill = 0;
	int                 cycle_count = 0;
	int unsigned        next_gap = 0;
	bit                 valid_up = 1'b0;
	bit                 quiet_tx = 1'b0;

	keyed_entry_list_engine_unit DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	always #5 clk = ~clk;

	// run ends here if the block stops answering
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("FAILURE");
		$finish;
	end

	// apply one request to the list and return the response it should produce
	function automatic kele_rsp_t list_outcome(kele_req_t r);
		kele_rsp_t          o;
		logic [VALUE_W-1:0] fast;
		logic [VALUE_W-1:0] slow;
		int                 hit;
		int                 n;
		o = '0;
		n = held_entries.size();
		hit = -1;
		if (r.action == ACT_APPEND || r.action == ACT_PREPEND) begin
			if (n >= DEPTH) begin
				o.status = ST_FULL;
			end else if (r.action == ACT_APPEND) begin
				held_entries.push_back(r.entry_value);
			end else begin
				held_entries.push_front(VALUE_W'(64'(r.model) * 64'(DECIMAL) + 64'(r.speed)));
			end
		end else if (r.action > ACT_EXTREMES) begin
			o.status = ST_OK;
		end else if (n == 0) begin
			o.status = ST_EMPTY;
		end else if (r.action == ACT_DELETE) begin
			// first entry whose model digits match the key
			for (int i = 0; i < n && hit < 0; i++) begin
				if ((held_entries[i] / DECIMAL) == 32'(r.model))
					hit = i;
			end
			if (hit < 0)
				o.status = ST_NOT_FOUND;
			else
				held_entries.delete(hit);
		end else if (r.action == ACT_ENDS) begin
			o.first_entry = held_entries[0];
			if (n >= 2)
				o.second_last_entry = held_entries[n-2];
		end else begin
			// earliest entry wins on equal speeds
			fast = held_entries[0];
			slow = held_entries[0];
			for (int i = 1; i < n; i++) begin
				if (held_entries[i] % DECIMAL > fast % DECIMAL)
					fast = held_entries[i];
				if (held_entries[i] % DECIMAL < slow % DECIMAL)
					slow = held_entries[i];
			end
			o.fastest_model = MODEL_W'(fast / DECIMAL);
			o.fastest_speed = SPEED_W'(fast % DECIMAL);
			o.slowest_model = MODEL_W'(slow / DECIMAL);
			o.slowest_speed = SPEED_W'(slow % DECIMAL);
		end
		o.count = COUNT_W'(held_entries.size());
		outcome_tally[o.status]++;
		if (held_entries.size() > peak_fill)
			peak_fill = held_entries.size();
		return o;
	endfunction

	function automatic void add_row(logic [ACTION_W-1:0] act, logic [VALUE_W-1:0] value,
			logic [MODEL_W-1:0] key, logic [SPEED_W-1:0] spd, bit typed,
			logic [STATUS_W-1:0] st, int cnt, logic [VALUE_W-1:0] first,
			logic [VALUE_W-1:0] second_last);
		stim_row_t row;
		row.req = '{action: act, entry_value: value, model: key, speed: spd};
		row.typed = typed;
		row.want = '0;
		row.want.status = st;
		row.want.count = COUNT_W'(cnt);
		row.want.first_entry = first;
		row.want.second_last_entry = second_last;
		directed_plan.push_back(row);
	endfunction

	// models cluster on a few small values to get duplicate keys
	function automatic logic [MODEL_W-1:0] pick_model();
		int unsigned sel;
		sel = $urandom_range(9);
		if (sel < 4)
			return MODEL_W'($urandom_range(15));
		else if (sel < 9)
			return MODEL_W'($urandom_range(99999));
		return MODEL_W'($urandom_range((1 << MODEL_W) - 1));
	endfunction

	// speeds cluster on a few values to get ties
	function automatic logic [SPEED_W-1:0] pick_speed();
		int unsigned sel;
		sel = $urandom_range(9);
		if (sel == 0)
			return SPEED_W'(0);
		else if (sel == 1)
			return SPEED_W'(500);
		else if (sel == 2)
			return SPEED_W'(999);
		else if (sel < 9)
			return SPEED_W'($urandom_range(999));
		return SPEED_W'($urandom_range((1 << SPEED_W) - 1));
	endfunction

	// random request biased toward growing or shrinking the list
	function automatic kele_req_t make_random_request(bit filling);
		kele_req_t   r;
		int unsigned roll;
		int unsigned ins_end;
		int unsigned del_end;
		int          n;
		n = held_entries.size();
		r.entry_value = VALUE_W'($urandom_range((1 << VALUE_W) - 1));
		r.model = pick_model();
		r.speed = pick_speed();
		ins_end = filling ? 55 : 10;
		del_end = filling ? 70 : 70;
		roll = $urandom_range(99);
		if (roll < ins_end) begin
			r.action = $urandom_range(1) ? ACT_PREPEND : ACT_APPEND;
			if ($urandom_range(19) != 0)
				r.entry_value = VALUE_W'(64'(pick_model()) * 64'(DECIMAL)
					+ 64'($urandom_range(999)));
		end else if (roll < del_end) begin
			r.action = ACT_DELETE;
			if (n > 0 && $urandom_range(99) < 85)
				r.model = MODEL_W'(held_entries[$urandom_range(n - 1)] / DECIMAL);
		end else if (roll < 84) begin
			r.action = ACT_ENDS;
		end else if (roll < 95) begin
			r.action = ACT_EXTREMES;
		end else begin
			r.action = ACT_SPARE_LO + ACTION_W'($urandom_range(ACT_SPARE_HI - ACT_SPARE_LO));
		end
		return r;
	endfunction

	// present one request beat, hold it until taken, then record what should come back
	task automatic drive_request(kele_req_t r, bit typed, kele_rsp_t want);
		kele_rsp_t predicted;
		repeat (next_gap) @(posedge clk);
		req <= r;
		req_valid <= 1'b1;
		do @(posedge clk); while (!req_ready);
		predicted = list_outcome(r);
		awaited_rsp.push_back(typed ? want : predicted);
		next_gap = quiet_tx ? 0 : $urandom_range(15);
		valid_up = (next_gap == 0);
		if (!valid_up)
			req_valid <= 1'b0;
	endtask

	// stop sending until every outstanding response has arrived
	task automatic drain_responses();
		if (valid_up) begin
			req_valid <= 1'b0;
			valid_up = 1'b0;
		end
		while (awaited_rsp.size() != 0) @(posedge clk);
	endtask

	function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$error("%s mismatch: expected %0d, got %0d", name, want, got);
			mismatch_count++;
		end
	endfunction

	// response side: random stalls, field checks against the oldest expectation
	initial begin
		kele_rsp_t   want;
		int          stall;
		int          beats;
		bit          quiet_rx;
		beats = 0;
		quiet_rx = 1'b0;
		stall = $urandom_range(15);
		while (!arst_n) @(posedge clk);
		forever begin
			@(posedge clk);
			if (rsp_valid && rsp_ready) begin
				if (awaited_rsp.size() == 0) begin
					$error("response beat with no request outstanding");
					mismatch_count++;
				end else begin
					want = awaited_rsp.pop_front();
					compare_field("status", want.status, rsp.status);
					compare_field("count", want.count, rsp.count);
					compare_field("first_entry", want.first_entry, rsp.first_entry);
					compare_field("second_last_entry", want.second_last_entry,
						rsp.second_last_entry);
					compare_field("fastest_model", want.fastest_model, rsp.fastest_model);
					compare_field("fastest_speed", want.fastest_speed, rsp.fastest_speed);
					compare_field("slowest_model", want.slowest_model, rsp.slowest_model);
					compare_field("slowest_speed", want.slowest_speed, rsp.slowest_speed);
				end
				beats++;
				if (beats % 64 == 0)
					quiet_rx = ($urandom_range(3) == 0);
				stall = quiet_rx ? 0 : $urandom_range(15);
				if (stall != 0)
					rsp_ready <= 1'b0;
			end else if (!rsp_ready) begin
				stall--;
				if (stall <= 0)
					rsp_ready <= 1'b1;
			end
		end
	end

	// request side: reset, directed table, random mix, drain and verdict
	initial begin
		bit filling;
		filling = 1'b1;

		// empty list, spare code, single entry
		add_row(ACT_ENDS,      27'd0,        17'd0,      10'd0,    1, ST_EMPTY, 0, 27'd0, 27'd0);
		add_row(ACT_EXTREMES,  27'd0,        17'd0,      10'd0,    1, ST_EMPTY, 0, 27'd0, 27'd0);
		add_row(ACT_DELETE,    27'd0,        17'd0,      10'd0,    1, ST_EMPTY, 0, 27'd0, 27'd0);
		add_row(ACT_SPARE_LO,  27'd0,        17'd0,      10'd0,    1, ST_OK,    0, 27'd0, 27'd0);
		add_row(ACT_APPEND,    27'd99999999, 17'd0,      10'd0,    1, ST_OK,    1, 27'd0, 27'd0);
		add_row(ACT_ENDS,      27'd0,        17'd0,      10'd0,    1, ST_OK,    1,
			27'd99999999, 27'd0);
		add_row(ACT_PREPEND,   27'd0,        17'd0,      10'd0,    1, ST_OK,    2, 27'd0, 27'd0);
		// field extremes, speed overflow into the model digits, oversized values
		add_row(ACT_APPEND,    27'd0,        17'd0,      10'd0,    0, ST_OK,    0, 27'd0, 27'd0);
		add_row(ACT_PREPEND,   27'd0,        17'd99999,  10'd999,  0, ST_OK,    0, 27'd0, 27'd0);
		add_row(ACT_PREPEND,   27'd0,        17'd1,      10'd1023, 0, ST_OK,    0, 27'd0, 27'd0);
		add_row(ACT_APPEND,    27'h7FFFFFF,  17'd0,      10'd0,    0, ST_OK,    0, 27'd0, 27'd0);
		add_row(ACT_ENDS,      27'd0,        17'd0,      10'd0,    0, ST_OK,    0, 27'd0, 27'd0);
		add_row(ACT_EXTREMES,  27'd0,        17'd0,      10'd0,    0, ST_OK,    0, 27'd0, 27'd0);
		// speed ties on both ends
		add_row(ACT_APPEND,    27'd5000999,  17'd0,      10'd0,    0, ST_OK,    0, 27'd0, 27'd0);
		add_row(ACT_APPEND,    27'd7000000,  17'd0,      10'd0,    0, ST_OK,    0, 27'd0, 27'd0);
		add_row(ACT_EXTREMES,  27'd0,        17'd0,      10'd0,    0, ST_OK,    0, 27'd0, 27'd0);
		// absent key, hits, remaining spare codes
		add_row(ACT_DELETE,    27'd0,        17'd77777,  10'd0,    1, ST_NOT_FOUND, 8,
			27'd0, 27'd0);
		add_row(ACT_DELETE,    27'd0,        17'd0,      10'd0,    0, ST_OK,    0, 27'd0, 27'd0);
		add_row(ACT_DELETE,    27'd0,        17'd131071, 10'd0,    0, ST_OK,    0, 27'd0, 27'd0);
		add_row(ACT_SPARE_MID, 27'h7FFFFFF,  17'd131071, 10'd1023, 0, ST_OK,    0, 27'd0, 27'd0);
		add_row(ACT_SPARE_HI,  27'd0,        17'd0,      10'd0,    0, ST_OK,    0, 27'd0, 27'd0);
		add_row(ACT_DELETE,    27'd0,        17'd99999,  10'd0,    0, ST_OK,    0, 27'd0, 27'd0);
		add_row(ACT_ENDS,      27'd0,        17'd0,      10'd0,    0, ST_OK,    0, 27'd0, 27'd0);
		add_row(ACT_EXTREMES,  27'd0,        17'd0,      10'd0,    0, ST_OK,    0, 27'd0, 27'd0);
		add_row(ACT_PREPEND,   27'd0,        17'd131071, 10'd1023, 0, ST_OK,    0, 27'd0, 27'd0);

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_plan[i])
			drive_request(directed_plan[i].req, directed_plan[i].typed, directed_plan[i].want);
		drain_responses();

		// random part swings the list between empty and full
		for (int n = 0; n < RANDOM_REQS; n++) begin
			if (filling && held_entries.size() == DEPTH && $urandom_range(5) == 0)
				filling = 1'b0;
			else if (!filling && held_entries.size() == 0 && $urandom_range(3) == 0)
				filling = 1'b1;
			if (n % 100 == 0)
				quiet_tx = ($urandom_range(3) == 0);
			if (n % 300 == 299)
				drain_responses();
			drive_request(make_random_request(filling), 1'b0, '0);
		end

		drain_responses();
		repeat (2 * DEPTH + 20) @(posedge clk);

		$display("ran %0d requests: %0d ok, %0d full drops, %0d key misses, %0d on empty list",
			directed_plan.size() + RANDOM_REQS, outcome_tally[ST_OK], outcome_tally[ST_FULL],
			outcome_tally[ST_NOT_FOUND], outcome_tally[ST_EMPTY]);
		$display("list reached %0d of %0d entries, %0d mismatches", peak_fill, DEPTH,
			mismatch_count);
		if (mismatch_count == 0 && awaited_rsp.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
